// ===== rtl/core/prr_pkg.sv =====
package prr_pkg;

    // Field and register widths
    localparam int DATA_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Serial arithmetic unit operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 16;

    // Quotient magnitudes saturate at 2**SAT_POS
    localparam int SAT_POS = 62;
    localparam int MAG_W   = SAT_POS + 1;

    // Signed accumulator for the drive sum, enough for FRAC_BITS up to 24
    localparam int ACC_W = 64;

    localparam int FRAC_BITS_DEF = 16;

    // Milliseconds per second
    localparam logic [DEN_W-1:0] MS_PER_S = 16'd1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd6;

    // Register reset values
    localparam logic [DATA_W-1:0] RST_TARGET    = 16'd125;
    localparam logic [DATA_W-1:0] RST_GAIN_P    = 16'hFFF6;
    localparam logic [DATA_W-1:0] RST_GAIN_I    = 16'hFFFD;
    localparam logic [DATA_W-1:0] RST_GAIN_D    = 16'hFFFB;
    localparam logic [DATA_W-1:0] RST_SAMPLE    = 16'd250;
    localparam logic [DATA_W-1:0] RST_DRIVE_MAX = 16'd10000;
    localparam logic [DATA_W-1:0] RST_DRIVE_MIN = 16'd0;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_RUN_MUL,
        ALU_RUN_DIV
    } t_alu_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_GO,
        S_WAIT,
        S_INTEG,
        S_ICLAMP,
        S_DSUB,
        S_PADD,
        S_TCLAMP,
        S_OUT
    } t_seq_state;

    typedef enum logic [2:0] {
        STEP_KI_SP,
        STEP_IMAG,
        STEP_DIV_I,
        STEP_KD_DIN,
        STEP_DMAG,
        STEP_DIV_D,
        STEP_KP_ERR
    } t_seq_step;

endpackage

// ===== rtl/core/prr_serial_alu.sv =====
module prr_serial_alu #(
    parameter int FRAC_BITS = prr_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prr_pkg::t_alu_req            i_req,
    input  logic [prr_pkg::MUL_A_W-1:0]  i_mul_a,
    input  logic [prr_pkg::MUL_B_W-1:0]  i_mul_b,
    input  logic [prr_pkg::PROD_W-1:0]   i_div_num,
    input  logic [prr_pkg::DEN_W-1:0]    i_div_den,
    output prr_pkg::t_alu_rsp            o_rsp,
    output logic [prr_pkg::PROD_W-1:0]   o_prod,
    output logic [prr_pkg::MAG_W-1:0]    o_quo
);

    // Quotient bits: numerator bits followed by FRAC_BITS zero bits
    localparam int  QW       = prr_pkg::PROD_W + FRAC_BITS;
    localparam int  CW       = $clog2(QW);
    localparam bit  CAN_SAT  = QW > prr_pkg::SAT_POS;
    localparam int  SAT_LAST = CAN_SAT ? QW - 1 - prr_pkg::SAT_POS : 0;
    localparam int  AW       = prr_pkg::MUL_A_W;
    localparam int  BW       = prr_pkg::MUL_B_W;
    localparam int  NW       = prr_pkg::PROD_W;
    localparam int  DW       = prr_pkg::DEN_W;
    localparam int  SP       = prr_pkg::SAT_POS;

    prr_pkg::t_alu_state r_state, n_state;

    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_a;
    logic [AW-1:0] r_hi;
    logic [BW-1:0] r_lo;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [SP-1:0] r_quo;
    logic          r_sat;
    logic          r_done;

    logic          last;
    logic [AW:0]   mul_t;
    logic [DW:0]   div_t;
    logic [DW:0]   div_d;
    logic          div_ge;

    always_comb begin
        mul_t  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(AW+1){1'b0}});
        div_t  = {r_rem, r_num[NW-1]};
        div_ge = div_t >= {1'b0, r_den};
        div_d  = div_t - {1'b0, r_den};
        if (r_state == prr_pkg::ALU_RUN_MUL) begin
            last = r_cnt == CW'(BW - 1);
        end else begin
            last = r_cnt == CW'(QW - 1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prr_pkg::ALU_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == prr_pkg::ALU_DIV) ? prr_pkg::ALU_RUN_DIV
                                                             : prr_pkg::ALU_RUN_MUL;
                end
            end
            prr_pkg::ALU_RUN_MUL,
            prr_pkg::ALU_RUN_DIV: begin
                if (last) begin
                    n_state = prr_pkg::ALU_IDLE;
                end
            end
            default: n_state = prr_pkg::ALU_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.busy = r_state != prr_pkg::ALU_IDLE;
        o_rsp.done = r_done;
        o_prod     = {r_hi, r_lo};
        o_quo      = r_sat ? {1'b1, {SP{1'b0}}} : {1'b0, r_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prr_pkg::ALU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state != prr_pkg::ALU_IDLE) && last;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            prr_pkg::ALU_IDLE: begin
                r_cnt <= '0;
                if (i_req.start) begin
                    r_a   <= i_mul_a;
                    r_hi  <= '0;
                    r_lo  <= i_mul_b;
                    r_num <= i_div_num;
                    r_den <= i_div_den;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_sat <= 1'b0;
                end
            end
            prr_pkg::ALU_RUN_MUL: begin
                // add multiplicand on a one bit, shift product right
                r_hi  <= mul_t[AW:1];
                r_lo  <= {mul_t[0], r_lo[BW-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            prr_pkg::ALU_RUN_DIV: begin
                // restoring step; quotient bits above the saturation point only set r_sat
                r_rem <= div_ge ? div_d[DW-1:0] : div_t[DW-1:0];
                r_num <= {r_num[NW-2:0], 1'b0};
                r_quo <= {r_quo[SP-2:0], div_ge};
                if (div_ge && CAN_SAT && (r_cnt <= CW'(SAT_LAST))) begin
                    r_sat <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: r_cnt <= '0;
        endcase
    end

endmodule

// ===== rtl/core/pid_rate_regulator.sv =====
// PID rate regulator with integral clamp.
//
// Input channel: i_in_valid / o_in_stall carry one request of a millisecond
// timestamp (i_now_ms) and a measured value (i_measured). Output channel:
// o_out_valid / i_out_stall carry one result request per input: o_drive and
// o_updated. Registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle, as the block does not
// enforce it. Indexes past the last register are dropped.
// One request is worked on at a time. A request that holds goes from the idle state
// through the hand-off state into the output register. An update goes through a
// setup step, five 16-bit multiplies and two (48+FRAC_BITS)-bit divides on the
// shared bit-serial unit, then sums and clamps. In both cases the next request is
// taken once the result is handed off.
//
// The output register parts the two sides: a new request is taken while a
// result still waits. If the receiver stalls, the finished result holds in
// the sequencer until the output register frees up.
//
// Reset loads the register defaults, clears integrator, last measurement,
// last update time and held drive, and marks the next request as the first.
module pid_rate_regulator #(
    parameter int FRAC_BITS = prr_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [prr_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [prr_pkg::DATA_W-1:0]     i_measured,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [prr_pkg::DATA_W-1:0]     o_drive,
    output logic                           o_updated,
    input  logic                           i_cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prr_pkg::DATA_W-1:0]     i_cfg_data
);

    localparam int DW = prr_pkg::DATA_W;
    localparam int TW = prr_pkg::TIME_W;
    localparam int AW = prr_pkg::ACC_W;
    localparam int MW = prr_pkg::MAG_W;
    // Integrator is kept clamped, so it is never negative
    localparam int IW = DW + FRAC_BITS;

    // Registers
    logic [DW-1:0] r_target, r_kp, r_ki, r_kd, r_sp, r_max, r_min;

    // Controller state
    logic [IW-1:0] r_integ;
    logic [DW-1:0] r_prev;
    logic [TW-1:0] r_last;
    logic [DW-1:0] r_drive_hold;
    logic          r_first;

    // Sequencer
    prr_pkg::t_seq_state r_state, n_state;
    prr_pkg::t_seq_step  r_step;

    // Working registers
    logic [TW-1:0]             r_now;
    logic [DW-1:0]             r_meas;
    logic                      r_upd;
    logic [DW-1:0]             r_err_mag, r_din_mag;
    logic                      r_err_neg, r_din_neg;
    logic [prr_pkg::PROD_W-1:0] r_mul;
    logic [MW-1:0]             r_inc, r_dterm;
    logic signed [AW-1:0]      r_sum;

    // Output register
    logic          r_out_valid;
    logic [DW-1:0] r_drive;
    logic          r_updated;

    // Serial unit
    prr_pkg::t_alu_req           alu_req;
    prr_pkg::t_alu_rsp           alu_rsp;
    logic [prr_pkg::MUL_A_W-1:0] alu_a;
    logic [prr_pkg::MUL_B_W-1:0] alu_b;
    logic [prr_pkg::DEN_W-1:0]   alu_den;
    logic [prr_pkg::PROD_W-1:0]  alu_prod;
    logic [MW-1:0]               alu_quo;

    logic          in_acc;
    logic          out_free;
    logic [DW:0]   err, err_n, din, din_n;
    logic [TW-1:0] delta;
    logic          upd;
    logic [DW-1:0] ki_mag, kd_mag, kp_mag;
    logic          s_i, s_d, s_p;
    logic signed [AW-1:0] inc_s, dterm_s, pterm_s;
    logic [IW-1:0] tot_c;

    // Clamp to [lo, hi] scaled; above hi wins when the limits cross
    function automatic logic [IW-1:0] f_clamp(input logic signed [AW-1:0] v,
                                              input logic [DW-1:0] lo16,
                                              input logic [DW-1:0] hi16);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        logic [IW-1:0]        res;
        hi = $signed(AW'({hi16, {FRAC_BITS{1'b0}}}));
        lo = $signed(AW'({lo16, {FRAC_BITS{1'b0}}}));
        if (v > hi) begin
            res = hi[IW-1:0];
        end else if (v < lo) begin
            res = lo[IW-1:0];
        end else begin
            res = v[IW-1:0];
        end
        return res;
    endfunction

    always_comb begin
        in_acc   = i_in_valid && !o_in_stall;
        out_free = !r_out_valid || !i_out_stall;

        err   = {1'b0, r_target} - {1'b0, i_measured};
        err_n = -err;
        din   = {1'b0, i_measured} - {1'b0, r_prev};
        din_n = -din;
        delta = i_now_ms - r_last;
        upd   = r_first || (delta > TW'(r_sp));

        ki_mag = r_ki[DW-1] ? DW'(-r_ki) : r_ki;
        kd_mag = r_kd[DW-1] ? DW'(-r_kd) : r_kd;
        kp_mag = r_kp[DW-1] ? DW'(-r_kp) : r_kp;
        s_i = r_ki[DW-1] ^ r_err_neg;
        s_d = r_kd[DW-1] ^ r_din_neg;
        s_p = r_kp[DW-1] ^ r_err_neg;

        // apply product signs to the magnitudes
        inc_s   = s_i ? -$signed(AW'(r_inc)) : $signed(AW'(r_inc));
        dterm_s = s_d ? -$signed(AW'(r_dterm)) : $signed(AW'(r_dterm));
        pterm_s = $signed(AW'({r_mul[prr_pkg::MUL_A_W-1:0], {FRAC_BITS{1'b0}}}));
        if (s_p) begin
            pterm_s = -pterm_s;
        end

        tot_c = f_clamp(r_sum, r_min, r_max);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prr_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = upd ? prr_pkg::S_PRE : prr_pkg::S_OUT;
                end
            end
            prr_pkg::S_PRE:  n_state = prr_pkg::S_GO;
            prr_pkg::S_GO:   n_state = prr_pkg::S_WAIT;
            prr_pkg::S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = (r_step == prr_pkg::STEP_KP_ERR) ? prr_pkg::S_INTEG
                                                               : prr_pkg::S_GO;
                end
            end
            prr_pkg::S_INTEG:  n_state = prr_pkg::S_ICLAMP;
            prr_pkg::S_ICLAMP: n_state = prr_pkg::S_DSUB;
            prr_pkg::S_DSUB:   n_state = prr_pkg::S_PADD;
            prr_pkg::S_PADD:   n_state = prr_pkg::S_TCLAMP;
            prr_pkg::S_TCLAMP: n_state = prr_pkg::S_OUT;
            prr_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = prr_pkg::S_IDLE;
                end
            end
            default: n_state = prr_pkg::S_IDLE;
        endcase
    end

    // Outputs and operand select for the serial unit
    always_comb begin
        o_in_stall  = r_state != prr_pkg::S_IDLE;
        o_out_valid = r_out_valid;
        o_drive     = r_drive;
        o_updated   = r_updated;

        alu_req.start = r_state == prr_pkg::S_GO;
        alu_req.op    = prr_pkg::ALU_MUL;
        alu_a         = r_mul[prr_pkg::MUL_A_W-1:0];
        alu_b         = r_err_mag;
        alu_den       = prr_pkg::MS_PER_S;
        unique case (r_step)
            prr_pkg::STEP_KI_SP: begin
                alu_a = prr_pkg::MUL_A_W'(ki_mag);
                alu_b = r_sp;
            end
            prr_pkg::STEP_IMAG: alu_b = r_err_mag;
            prr_pkg::STEP_DIV_I: alu_req.op = prr_pkg::ALU_DIV;
            prr_pkg::STEP_KD_DIN: begin
                alu_a = prr_pkg::MUL_A_W'(kd_mag);
                alu_b = r_din_mag;
            end
            prr_pkg::STEP_DMAG: alu_b = prr_pkg::MS_PER_S;
            prr_pkg::STEP_DIV_D: begin
                alu_req.op = prr_pkg::ALU_DIV;
                // a zero period divides by one
                alu_den    = (r_sp == '0) ? prr_pkg::DEN_W'(1) : r_sp;
            end
            prr_pkg::STEP_KP_ERR: begin
                alu_a = prr_pkg::MUL_A_W'(kp_mag);
                alu_b = r_err_mag;
            end
            default: alu_req.op = prr_pkg::ALU_MUL;
        endcase
    end

    prr_serial_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (alu_req),
        .i_mul_a   (alu_a),
        .i_mul_b   (alu_b),
        .i_div_num (r_mul),
        .i_div_den (alu_den),
        .o_rsp     (alu_rsp),
        .o_prod    (alu_prod),
        .o_quo     (alu_quo)
    );

    // Control, registers and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= prr_pkg::S_IDLE;
            r_target     <= prr_pkg::RST_TARGET;
            r_kp         <= prr_pkg::RST_GAIN_P;
            r_ki         <= prr_pkg::RST_GAIN_I;
            r_kd         <= prr_pkg::RST_GAIN_D;
            r_sp         <= prr_pkg::RST_SAMPLE;
            r_max        <= prr_pkg::RST_DRIVE_MAX;
            r_min        <= prr_pkg::RST_DRIVE_MIN;
            r_integ      <= '0;
            r_prev       <= '0;
            r_last       <= '0;
            r_drive_hold <= '0;
            r_first      <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    prr_pkg::CFG_TARGET:    r_target <= i_cfg_data;
                    prr_pkg::CFG_GAIN_P:    r_kp     <= i_cfg_data;
                    prr_pkg::CFG_GAIN_I:    r_ki     <= i_cfg_data;
                    prr_pkg::CFG_GAIN_D:    r_kd     <= i_cfg_data;
                    prr_pkg::CFG_SAMPLE:    r_sp     <= i_cfg_data;
                    prr_pkg::CFG_DRIVE_MAX: r_max    <= i_cfg_data;
                    prr_pkg::CFG_DRIVE_MIN: r_min    <= i_cfg_data;
                    default: ;
                endcase
            end

            // bring a fresh integrator into the limits on the first update
            if (r_state == prr_pkg::S_PRE && r_first) begin
                r_integ <= f_clamp($signed(AW'(r_integ)), r_min, r_max);
            end
            if (r_state == prr_pkg::S_ICLAMP) begin
                r_integ <= tot_c;
            end
            if (r_state == prr_pkg::S_TCLAMP) begin
                r_drive_hold <= tot_c[IW-1:FRAC_BITS];
                r_prev       <= r_meas;
                r_last       <= r_now;
                r_first      <= 1'b0;
            end

            // load the result when the output register frees, else drop it once taken
            if (r_state == prr_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now     <= i_now_ms;
            r_meas    <= i_measured;
            r_upd     <= upd;
            r_step    <= prr_pkg::STEP_KI_SP;
            r_err_neg <= err[DW];
            r_err_mag <= err[DW] ? err_n[DW-1:0] : err[DW-1:0];
            // no derivative kick on the first update
            r_din_neg <= din[DW] && !r_first;
            r_din_mag <= r_first ? '0 : (din[DW] ? din_n[DW-1:0] : din[DW-1:0]);
        end

        if (r_state == prr_pkg::S_WAIT && alu_rsp.done) begin
            unique case (r_step)
                prr_pkg::STEP_DIV_I: r_inc   <= alu_quo;
                prr_pkg::STEP_DIV_D: r_dterm <= alu_quo;
                default:             r_mul   <= alu_prod;
            endcase
            unique case (r_step)
                prr_pkg::STEP_KI_SP:  r_step <= prr_pkg::STEP_IMAG;
                prr_pkg::STEP_IMAG:   r_step <= prr_pkg::STEP_DIV_I;
                prr_pkg::STEP_DIV_I:  r_step <= prr_pkg::STEP_KD_DIN;
                prr_pkg::STEP_KD_DIN: r_step <= prr_pkg::STEP_DMAG;
                prr_pkg::STEP_DMAG:   r_step <= prr_pkg::STEP_DIV_D;
                prr_pkg::STEP_DIV_D:  r_step <= prr_pkg::STEP_KP_ERR;
                default:              r_step <= prr_pkg::STEP_KP_ERR;
            endcase
        end

        unique case (r_state)
            prr_pkg::S_INTEG: r_sum <= $signed(AW'(r_integ)) + inc_s;
            prr_pkg::S_DSUB:  r_sum <= $signed(AW'(r_integ)) - dterm_s;
            prr_pkg::S_PADD:  r_sum <= r_sum + pterm_s;
            default: ;
        endcase

        if (r_state == prr_pkg::S_OUT && out_free) begin
            r_drive   <= r_drive_hold;
            r_updated <= r_upd;
        end
    end

    // A result appears only out of the hand-off state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == prr_pkg::S_OUT))
        else $error("result valid rose outside the hand-off state");

    // The serial unit reports done only to a waiting sequencer
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> r_state == prr_pkg::S_WAIT)
        else $error("serial unit done while the sequencer is not waiting");

    // A start never hits a busy serial unit
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("serial unit started while busy");

    // An idle sequencer leaves the serial unit idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == prr_pkg::S_IDLE |-> !alu_rsp.busy && !alu_rsp.done)
        else $error("serial unit active while the sequencer is idle");

endmodule
